### rtl/core/gre_pkg.sv
`timescale 1ns / 1ps

package gre_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [BIT_W-1:0]     bitpos_t;

  localparam logic CMD_ELIM = 1'b0;
  localparam logic CMD_ROW  = 1'b1;

  function automatic bitpos_t msb_pos(input word_t v);
    bitpos_t pos;
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

### rtl/core/gre_elim_store.sv
`timescale 1ns / 1ps

module gre_elim_store #(
  parameter int COLS  = 256,
  parameter int WORDS = 8,
  localparam int CW   = $clog2(COLS),
  localparam int SAW  = $clog2(COLS * WORDS)
) (
  input  logic           clk,
  input  logic           st_rd_en,
  input  logic [SAW-1:0] st_rd_addr,
  output gre_pkg::word_t st_rd_data,
  input  logic           st_wr_en,
  input  logic [SAW-1:0] st_wr_addr,
  input  gre_pkg::word_t st_wr_data,
  input  logic           vl_rd_en,
  input  logic [CW-1:0]  vl_rd_addr,
  output logic           vl_rd_data,
  input  logic           vl_wr_en,
  input  logic [CW-1:0]  vl_wr_addr,
  input  logic           vl_wr_data
);
  import gre_pkg::*;

  word_t store_mem [COLS*WORDS];
  logic  valid_mem [COLS];

  always_ff @(posedge clk) begin
    if (st_rd_en) begin
      st_rd_data <= store_mem[st_rd_addr];
    end
    if (st_wr_en) begin
      store_mem[st_wr_addr] <= st_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (vl_rd_en) begin
      vl_rd_data <= valid_mem[vl_rd_addr];
    end
    if (vl_wr_en) begin
      valid_mem[vl_wr_addr] <= vl_wr_data;
    end
  end

endmodule

### rtl/core/gre_row_buf.sv
`timescale 1ns / 1ps

module gre_row_buf #(
  parameter int WORDS = 8,
  localparam int RAW  = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic           clk,
  input  logic           rd_en,
  input  logic [RAW-1:0] rd_addr,
  output gre_pkg::word_t rd_data,
  input  logic           wr_en,
  input  logic [RAW-1:0] wr_addr,
  input  gre_pkg::word_t wr_data
);
  import gre_pkg::*;

  word_t row_mem [WORDS];

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= row_mem[rd_addr];
    end
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/core/gf2_row_reduction_engine_top.sv
// Eliminator load beat: accepted without stalling the input, no result.
// Row to reduce: one beat per word; after the last word a lead scan pass, then an
// eliminator XOR pass for a valid pivot or an install copy for a free one, all paced
// by the one read port and one write port of the row buffer and eliminator store.
// Results: WORDS beats, read (EMIT_RD) and loaded (EMIT_LD); input reopens after the last.
// Reset: synchronous, active low; a sweep of COLS entries clears valid bits, input stalled.
`timescale 1ns / 1ps

module gf2_row_reduction_engine_top #(
  parameter int COLS  = 256,
  parameter int WORDS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_command,
  input  logic [2:0]     in_word_index,
  input  gre_pkg::word_t in_word_data,
  input  logic [7:0]     in_pivot_column,
  input  logic           in_row_last,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_word_index,
  output gre_pkg::word_t out_word,
  output logic           out_last,
  output logic           out_became_eliminator,
  output logic           out_row_zero,
  output logic [7:0]     out_lead_column
);
  import gre_pkg::*;

  localparam int CW  = $clog2(COLS);
  localparam int SAW = $clog2(COLS * WORDS);
  localparam int RAW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LW  = $clog2(WORD_BITS * WORDS + 1);
  localparam logic [RAW-1:0] LAST_W  = RAW'(WORDS - 1);
  localparam logic [CW-1:0]  LAST_C  = CW'(COLS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PASS, S_PASS_END, S_LOOK, S_CHECK, S_EMIT_RD, S_EMIT_LD
  } state_t;

  typedef enum logic [1:0] {M_SCAN, M_XOR, M_COPY} mode_t;

  state_t         state_r, state_nxt;
  mode_t          mode_r, mode_nxt;
  logic [CW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [RAW-1:0] iss_w_r, iss_w_nxt;
  logic           iss_act_r, iss_act_nxt;
  logic           p_v_r, p_v_nxt;
  logic [RAW-1:0] p_w_r, p_w_nxt;
  logic [LW-1:0]  lead_acc_r, lead_acc_nxt;
  logic [LW-1:0]  lead_r, lead_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic           installed_r, installed_nxt;
  logic [RAW-1:0] em_w_r, em_w_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [2:0]     out_idx_r, out_idx_nxt;
  word_t          out_word_r, out_word_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_became_r, out_became_nxt;
  logic           out_zero_r, out_zero_nxt;
  logic [7:0]     out_lead_r, out_lead_nxt;

  logic           st_rd_en, st_wr_en;
  logic [SAW-1:0] st_rd_addr, st_wr_addr, st_base;
  word_t          st_rd_data, st_wr_data;
  logic           vl_rd_en, vl_rd_data, vl_wr_en, vl_wr_data;
  logic [CW-1:0]  vl_rd_addr, vl_wr_addr;
  logic           rb_rd_en, rb_wr_en;
  logic [RAW-1:0] rb_rd_addr, rb_wr_addr;
  word_t          rb_rd_data, rb_wr_data;

  word_t          pass_word;
  logic [LW-1:0]  lead_cand;
  logic [CW-1:0]  col_cand;
  logic [31:0]    lead_m1;
  logic           pivot_ok, widx_ok;

  gre_elim_store #(.COLS(COLS), .WORDS(WORDS)) u_store (
    .clk        (clk),
    .st_rd_en   (st_rd_en),
    .st_rd_addr (st_rd_addr),
    .st_rd_data (st_rd_data),
    .st_wr_en   (st_wr_en),
    .st_wr_addr (st_wr_addr),
    .st_wr_data (st_wr_data),
    .vl_rd_en   (vl_rd_en),
    .vl_rd_addr (vl_rd_addr),
    .vl_rd_data (vl_rd_data),
    .vl_wr_en   (vl_wr_en),
    .vl_wr_addr (vl_wr_addr),
    .vl_wr_data (vl_wr_data)
  );

  gre_row_buf #(.WORDS(WORDS)) u_row (
    .clk     (clk),
    .rd_en   (rb_rd_en),
    .rd_addr (rb_rd_addr),
    .rd_data (rb_rd_data),
    .wr_en   (rb_wr_en),
    .wr_addr (rb_wr_addr),
    .wr_data (rb_wr_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign st_base   = SAW'(32'(col_r) * WORDS);
  assign pass_word = rb_rd_data ^ ((mode_r == M_XOR) ? st_rd_data : '0);
  assign lead_cand = LW'(32'(p_w_r) * WORD_BITS + 32'(msb_pos(pass_word)) + 32'd1);
  assign lead_m1   = 32'(lead_r) - 32'd1;
  assign col_cand  = CW'(lead_m1);
  assign pivot_ok  = 32'(in_pivot_column) < COLS;
  assign widx_ok   = 32'(in_word_index) < WORDS;

  assign out_valid             = out_valid_r;
  assign out_word_index        = out_idx_r;
  assign out_word              = out_word_r;
  assign out_last              = out_last_r;
  assign out_became_eliminator = out_became_r;
  assign out_row_zero          = out_zero_r;
  assign out_lead_column       = out_lead_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    clr_cnt_nxt    = clr_cnt_r;
    iss_w_nxt      = iss_w_r;
    iss_act_nxt    = iss_act_r;
    p_v_nxt        = p_v_r;
    p_w_nxt        = p_w_r;
    lead_acc_nxt   = lead_acc_r;
    lead_nxt       = lead_r;
    col_nxt        = col_r;
    installed_nxt  = installed_r;
    em_w_nxt       = em_w_r;
    out_valid_nxt  = out_valid_r;
    out_idx_nxt    = out_idx_r;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    out_became_nxt = out_became_r;
    out_zero_nxt   = out_zero_r;
    out_lead_nxt   = out_lead_r;

    st_rd_en   = 1'b0;
    st_rd_addr = st_base + SAW'(32'(iss_w_r));
    st_wr_en   = 1'b0;
    st_wr_addr = st_base + SAW'(32'(p_w_r));
    st_wr_data = rb_rd_data;
    vl_rd_en   = 1'b0;
    vl_rd_addr = col_cand;
    vl_wr_en   = 1'b0;
    vl_wr_addr = col_r;
    vl_wr_data = 1'b1;
    rb_rd_en   = 1'b0;
    rb_rd_addr = iss_w_r;
    rb_wr_en   = 1'b0;
    rb_wr_addr = p_w_r;
    rb_wr_data = pass_word;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        vl_wr_en    = 1'b1;
        vl_wr_addr  = clr_cnt_r;
        vl_wr_data  = 1'b0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_C) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_ELIM) begin
            if (pivot_ok) begin
              st_wr_en   = widx_ok;
              st_wr_addr = SAW'(32'(in_pivot_column) * WORDS + 32'(in_word_index));
              st_wr_data = in_word_data;
              vl_wr_en   = in_row_last;
              vl_wr_addr = CW'(32'(in_pivot_column));
            end
          end else begin
            rb_wr_en   = widx_ok;
            rb_wr_addr = RAW'(32'(in_word_index));
            rb_wr_data = in_word_data;
            if (in_row_last) begin
              installed_nxt = 1'b0;
              mode_nxt      = M_SCAN;
              iss_w_nxt     = '0;
              iss_act_nxt   = 1'b1;
              p_v_nxt       = 1'b0;
              lead_acc_nxt  = '0;
              state_nxt     = S_PASS;
            end
          end
        end
      end
      S_PASS: begin
        if (iss_act_r) begin
          rb_rd_en = 1'b1;
          st_rd_en = (mode_r == M_XOR);
          if (iss_w_r == LAST_W) begin
            iss_act_nxt = 1'b0;
          end else begin
            iss_w_nxt = iss_w_r + 1'b1;
          end
        end
        p_v_nxt = iss_act_r;
        p_w_nxt = iss_w_r;
        if (p_v_r) begin
          case (mode_r)
            M_XOR:   rb_wr_en = 1'b1;
            M_COPY:  st_wr_en = 1'b1;
            default: ;
          endcase
          if (pass_word != '0) begin
            lead_acc_nxt = lead_cand;
          end
          if (p_w_r == LAST_W) begin
            if (mode_r == M_COPY) begin
              vl_wr_en      = 1'b1;
              installed_nxt = 1'b1;
              em_w_nxt      = '0;
              state_nxt     = S_EMIT_RD;
            end else begin
              state_nxt = S_PASS_END;
            end
          end
        end
      end
      S_PASS_END: begin
        lead_nxt = lead_acc_r;
        // an XOR that fails to lower the lead ends the reduction
        if (mode_r == M_XOR && lead_acc_r >= lead_r) begin
          em_w_nxt  = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (lead_r == '0 || 32'(lead_r) > COLS) begin
          em_w_nxt  = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          col_nxt   = col_cand;
          vl_rd_en  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        mode_nxt     = vl_rd_data ? M_XOR : M_COPY;
        iss_w_nxt    = '0;
        iss_act_nxt  = 1'b1;
        p_v_nxt      = 1'b0;
        lead_acc_nxt = '0;
        state_nxt    = S_PASS;
      end
      S_EMIT_RD: begin
        rb_rd_en   = 1'b1;
        rb_rd_addr = em_w_r;
        rb_wr_en   = 1'b1;
        rb_wr_addr = em_w_r;
        rb_wr_data = '0;
        state_nxt  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = rb_rd_data;
          out_idx_nxt    = 3'(32'(em_w_r));
          out_last_nxt   = (em_w_r == LAST_W);
          out_became_nxt = installed_r;
          out_zero_nxt   = (lead_r == '0);
          out_lead_nxt   = (lead_r == '0) ? 8'd0 : lead_m1[7:0];
          if (em_w_r == LAST_W) begin
            state_nxt = S_IDLE;
          end else begin
            em_w_nxt  = em_w_r + 1'b1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      iss_act_r   <= 1'b0;
      p_v_r       <= 1'b0;
      lead_r      <= '0;
      installed_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      iss_w_r      <= iss_w_nxt;
      iss_act_r    <= iss_act_nxt;
      p_v_r        <= p_v_nxt;
      p_w_r        <= p_w_nxt;
      lead_acc_r   <= lead_acc_nxt;
      lead_r       <= lead_nxt;
      col_r        <= col_nxt;
      installed_r  <= installed_nxt;
      em_w_r       <= em_w_nxt;
      out_valid_r  <= out_valid_nxt;
      out_idx_r    <= out_idx_nxt;
      out_word_r   <= out_word_nxt;
      out_last_r   <= out_last_nxt;
      out_became_r <= out_became_nxt;
      out_zero_r   <= out_zero_nxt;
      out_lead_r   <= out_lead_nxt;
    end
  end

endmodule
